>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scheduler checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising edge while reset is released.
`define APTS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("scheduler assertion failed");

// Check a property on each rising edge, reset included.
`define APTS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scheduler reset assertion failed");

`endif

>>> src/apts_pkg.sv
// ---------------------------------------------------------------------------
// apts_pkg
// Widths, codes and defaults shared by the aging priority task scheduler.
// ---------------------------------------------------------------------------
package apts_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int OPC_W    = 2;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic [PRIO_W-1:0] PRIO_MAX  = 8'hFF;
    localparam logic [PRIO_W-1:0] THR_RESET = 8'd8;

    localparam logic [OPC_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OPC_W-1:0] OP_YIELD  = 2'd1;
    localparam logic [OPC_W-1:0] OP_EXIT   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

endpackage

>>> src/aging_priority_task_scheduler.sv
// ---------------------------------------------------------------------------
// aging_priority_task_scheduler
// Microcoded task-slot scheduler: create, yield and exit with priority aging.
// ---------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_ready, opcode, new_priority  | in
//  out     | out_valid, out_ready, slot, status,       | out
//          | granted_priority, freed                   |
//  cfg     | cfg_valid, cfg_ready, cfg_data            | in
//
//  Create scans for a free slot, then takes it or reports full; yield scans
//  the slots below hwm, the high-water mark; exit may free the current slot
//  and then yields. Each scan covers one slot per cycle.
//  Reset clears the allocated flags at once; priorities need no clearing.
//  A new item is taken whenever the sequencer is idle; a result waits in the
//  output register and stalls only the step that emits the next one.
// ---------------------------------------------------------------------------
module aging_priority_task_scheduler
    import apts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPC_W-1:0]    opcode,
    input  logic [PRIO_W-1:0]   new_priority,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SLOT_W-1:0]   slot,
    output logic [STATUS_W-1:0] status,
    output logic [PRIO_W-1:0]   granted_priority,
    output logic                freed,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PRIO_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef logic [3:0] step_t;

    localparam step_t U_IDLE   = 4'd0;
    localparam step_t U_CSCAN  = 4'd1;
    localparam step_t U_CDEC   = 4'd2;
    localparam step_t U_CTAKE  = 4'd3;
    localparam step_t U_CFULL  = 4'd4;
    localparam step_t U_ERD    = 4'd5;
    localparam step_t U_ECHK   = 4'd6;
    localparam step_t U_SSCAN  = 4'd7;
    localparam step_t U_SWAIT  = 4'd8;
    localparam step_t U_SDEC   = 4'd9;
    localparam step_t U_SNONE  = 4'd10;
    localparam step_t U_SGRANT = 4'd11;

    typedef enum logic [3:0] {
        A_NOP,
        A_ACCEPT,
        A_CSCAN,
        A_CTAKE,
        A_CFULL,
        A_RDCUR,
        A_EXITCHK,
        A_SSCAN,
        A_SNONE,
        A_SGRANT
    } act_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_END_OR_FREE,
        C_AT_CAP,
        C_IDX_LAST,
        C_NOT_FOUND
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  emit;
        step_t t_true;
        step_t t_false;
    } uword_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            U_IDLE:   w = '{A_ACCEPT,  C_DISPATCH,    1'b0, U_IDLE,   U_IDLE};
            U_CSCAN:  w = '{A_CSCAN,   C_END_OR_FREE, 1'b0, U_CDEC,   U_CSCAN};
            U_CDEC:   w = '{A_NOP,     C_AT_CAP,      1'b0, U_CFULL,  U_CTAKE};
            U_CTAKE:  w = '{A_CTAKE,   C_ALWAYS,      1'b1, U_IDLE,   U_IDLE};
            U_CFULL:  w = '{A_CFULL,   C_ALWAYS,      1'b1, U_IDLE,   U_IDLE};
            U_ERD:    w = '{A_RDCUR,   C_ALWAYS,      1'b0, U_ECHK,   U_ECHK};
            U_ECHK:   w = '{A_EXITCHK, C_ALWAYS,      1'b0, U_SSCAN,  U_SSCAN};
            U_SSCAN:  w = '{A_SSCAN,   C_IDX_LAST,    1'b0, U_SWAIT,  U_SSCAN};
            U_SWAIT:  w = '{A_NOP,     C_ALWAYS,      1'b0, U_SDEC,   U_SDEC};
            U_SDEC:   w = '{A_NOP,     C_NOT_FOUND,   1'b0, U_SNONE,  U_SGRANT};
            U_SNONE:  w = '{A_SNONE,   C_ALWAYS,      1'b1, U_IDLE,   U_IDLE};
            U_SGRANT: w = '{A_SGRANT,  C_ALWAYS,      1'b1, U_IDLE,   U_IDLE};
            default:  w = '{A_NOP,     C_ALWAYS,      1'b0, U_IDLE,   U_IDLE};
        endcase
        return w;
    endfunction

    logic [PRIO_W-1:0] prio_mem [SLOT_COUNT];

    step_t                step_reg,      step_next;
    logic [SLOT_COUNT-1:0] alloc_reg,    alloc_next;
    logic [CNT_W-1:0]     hwm_reg,       hwm_next;
    logic [SLOT_W-1:0]    cur_reg,       cur_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [PRIO_W-1:0]    thr_reg,       thr_next;
    logic [PRIO_W-1:0]    prio_in_reg,   prio_in_next;
    logic [CNT_W-1:0]     idx_reg,       idx_next;
    logic                 found_reg,     found_next;
    logic [SLOT_W-1:0]    best_reg,      best_next;
    logic [PRIO_W-1:0]    best_prio_reg, best_prio_next;
    logic                 freed_f_reg,   freed_f_next;
    logic                 pend_reg,      pend_next;
    logic [SLOT_W-1:0]    pend_idx_reg,  pend_idx_next;
    logic [PRIO_W-1:0]    rd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    slot_reg,      slot_next;
    logic [STATUS_W-1:0]  status_reg,    status_next;
    logic [PRIO_W-1:0]    gprio_reg,     gprio_next;
    logic                 freed_reg,     freed_next;

    uword_t            uw;
    logic              stall;
    logic              cond_true;
    logic [CNT_W-1:0]  idx_inc;
    logic [SLOT_W-1:0] idx_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [PRIO_W-1:0] wr_data;
    logic [PRIO_W-1:0] aged_prio;

    assign uw        = ucode(step_reg);
    assign stall     = uw.emit && out_valid_reg && !out_ready;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_slot  = idx_reg[SLOT_W-1:0];
    assign aged_prio = (best_prio_reg == PRIO_MAX) ? best_prio_reg : best_prio_reg + 8'd1;

    assign in_ready         = (uw.act == A_ACCEPT);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign slot             = slot_reg;
    assign status           = status_reg;
    assign granted_priority = gprio_reg;
    assign freed            = freed_reg;

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:      cond_true = 1'b1;
            C_END_OR_FREE: cond_true = (idx_reg == hwm_reg) || !alloc_reg[idx_slot];
            C_AT_CAP:      cond_true = (idx_reg == CNT_W'(SLOT_COUNT));
            C_IDX_LAST:    cond_true = (idx_inc >= hwm_reg);
            C_NOT_FOUND:   cond_true = !found_reg;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (uw.cond == C_DISPATCH)
        begin
            if (in_valid)
            begin
                case (opcode)
                    OP_CREATE: step_next = U_CSCAN;
                    OP_YIELD:  step_next = U_SSCAN;
                    OP_EXIT:   step_next = U_ERD;
                    default:   step_next = U_IDLE;
                endcase
            end
            else
            begin
                step_next = U_IDLE;
            end
        end
        else
        begin
            step_next = cond_true ? uw.t_true : uw.t_false;
        end
    end

    assign rd_addr = (uw.act == A_RDCUR) ? cur_reg : idx_slot;

    always_comb
    begin
        alloc_next     = alloc_reg;
        hwm_next       = hwm_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        thr_next       = cfg_valid ? cfg_data : thr_reg;
        prio_in_next   = prio_in_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_prio_next = best_prio_reg;
        freed_f_next   = freed_f_reg;
        pend_next      = 1'b0;
        pend_idx_next  = idx_slot;
        out_valid_next = out_valid_reg && !out_ready;
        slot_next      = slot_reg;
        status_next    = status_reg;
        gprio_next     = gprio_reg;
        freed_next     = freed_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_slot;
        wr_data        = prio_in_reg;

        if (pend_reg && (!found_reg || rd_data_reg < best_prio_reg))
        begin
            found_next     = 1'b1;
            best_next      = pend_idx_reg;
            best_prio_next = rd_data_reg;
        end

        if (!stall)
        begin
            case (uw.act)
                A_ACCEPT:
                begin
                    prio_in_next = new_priority;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    freed_f_next = 1'b0;
                end
                A_CSCAN:
                begin
                    if (!cond_true)
                        idx_next = idx_inc;
                end
                A_CTAKE:
                begin
                    wr_en              = 1'b1;
                    alloc_next[idx_slot] = 1'b1;
                    if (idx_reg == hwm_reg)
                        hwm_next = idx_inc;
                    out_valid_next = 1'b1;
                    slot_next      = idx_slot;
                    status_next    = STATUS_OK;
                    gprio_next     = '0;
                    freed_next     = 1'b0;
                end
                A_CFULL:
                begin
                    out_valid_next = 1'b1;
                    slot_next      = '0;
                    status_next    = STATUS_FULL;
                    gprio_next     = '0;
                    freed_next     = 1'b0;
                end
                A_EXITCHK:
                begin
                    if (cur_valid_reg && alloc_reg[cur_reg] && (rd_data_reg > thr_reg))
                    begin
                        alloc_next[cur_reg] = 1'b0;
                        freed_f_next        = 1'b1;
                    end
                end
                A_SSCAN:
                begin
                    pend_next = (idx_reg < hwm_reg) && alloc_reg[idx_slot];
                    idx_next  = idx_inc;
                end
                A_SNONE:
                begin
                    out_valid_next = 1'b1;
                    slot_next      = '0;
                    status_next    = STATUS_NONE;
                    gprio_next     = '0;
                    freed_next     = freed_f_reg;
                end
                A_SGRANT:
                begin
                    wr_en          = 1'b1;
                    wr_addr        = best_reg;
                    wr_data        = aged_prio;
                    cur_next       = best_reg;
                    cur_valid_next = 1'b1;
                    out_valid_next = 1'b1;
                    slot_next      = best_reg;
                    status_next    = STATUS_OK;
                    gprio_next     = best_prio_reg;
                    freed_next     = freed_f_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            prio_mem[wr_addr] <= wr_data;
        rd_data_reg <= prio_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= U_IDLE;
            alloc_reg     <= '0;
            hwm_reg       <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            thr_reg       <= THR_RESET;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            freed_f_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            alloc_reg     <= alloc_next;
            hwm_reg       <= hwm_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            thr_reg       <= thr_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            freed_f_reg   <= freed_f_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_in_reg   <= prio_in_next;
        best_reg      <= best_next;
        best_prio_reg <= best_prio_next;
        pend_idx_reg  <= pend_idx_next;
        slot_reg      <= slot_next;
        status_reg    <= status_next;
        gprio_reg     <= gprio_next;
        freed_reg     <= freed_next;
    end

endmodule

>>> src/apts_checker.sv
// ---------------------------------------------------------------------------
// apts_checker
// Port-level checks on the aging priority task scheduler, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module apts_checker
    import apts_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SLOT_W-1:0]   slot,
    input logic [STATUS_W-1:0] status,
    input logic [PRIO_W-1:0]   granted_priority,
    input logic                freed
);

    logic [SLOT_W+STATUS_W+PRIO_W:0] res_bus;
    logic                            full_res;
    logic                            none_res;
    logic                            res_zero;

    assign res_bus  = {slot, status, granted_priority, freed};
    assign full_res = out_valid && (status == STATUS_FULL);
    assign none_res = out_valid && (status == STATUS_NONE);
    assign res_zero = (slot == '0) && (granted_priority == '0);

    // hold a stalled result
    `APTS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(res_bus))

    // full table reports slot zero, no priority, nothing freed
    `APTS_ASSERT(a_full_fields, clk, rst_n, full_res |-> res_zero && !freed)

    // empty schedule reports slot zero and no priority
    `APTS_ASSERT(a_none_fields, clk, rst_n, none_res |-> res_zero)

    // drop any result while in reset
    `APTS_ASSERT_RST(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind aging_priority_task_scheduler apts_checker #(.SLOT_COUNT(SLOT_COUNT)) u_apts_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slot             (slot),
    .status           (status),
    .granted_priority (granted_priority),
    .freed            (freed)
);
